// ===== design/ctp_pkg.sv =====
// Shared types and constants for the cassette tone and pulse timer.
// Used by the top level only; the interfaces and the port checker do not import it.
package ctp_pkg;

	// Register map: register i lives at byte address 4*i.
	localparam int unsigned PADDR_W = 5;

	typedef enum logic [2:0] {
		REG_TONE_HALF_PERIOD  = 3'd0,
		REG_SAMPLES_PER_CYCLE = 3'd1,
		REG_CYCLES_PER_SAMPLE = 3'd2,
		REG_RECORD_ENABLE     = 3'd3,
		REG_PLAY_ENABLE       = 3'd4,
		REG_INITIAL_LEVEL     = 3'd5
	} reg_idx_t;

	// Register reset values.
	localparam logic [15:0] TONE_HALF_RESET   = 16'd208;
	localparam logic [23:0] SPC_Q24_RESET     = 24'd739875;
	localparam logic [25:0] CPS_Q16_RESET     = 26'd1486279;

	// Rounding offsets for the two fixed-point scalings.
	localparam logic [23:0] REC_ROUND  = 24'h800000;
	localparam logic [15:0] PLAY_ROUND = 16'h8000;

	// Largest reportable recorded length.
	localparam logic [23:0] REC_MAX = 24'hFFFFFF;

	typedef struct packed {
		logic        tone_enable;
		logic        tape_data;
		logic        pulse_avail;
		logic [23:0] next_pulse_len;
	} item_t;

	typedef struct packed {
		logic        tone;
		logic        cas_out;
		logic        cas_in;
		logic        pulse_taken;
		logic        rec_valid;
		logic [23:0] rec_len;
		logic        load_active;
	} result_t;

endpackage

// ===== design/ctp_if.sv =====
// Valid/ready channel interfaces for the tick items and the per-tick results.
// Field widths follow ctp_pkg.
interface ctp_in_if;
	logic        valid;
	logic        ready;
	logic        tone_enable;
	logic        tape_data;
	logic        pulse_avail;
	logic [23:0] next_pulse_len;

	modport source (output valid, output tone_enable, output tape_data,
		output pulse_avail, output next_pulse_len, input ready);
	modport sink (input valid, input tone_enable, input tape_data,
		input pulse_avail, input next_pulse_len, output ready);
endinterface

interface ctp_out_if;
	logic        valid;
	logic        ready;
	logic        tone;
	logic        cas_out;
	logic        cas_in;
	logic        pulse_taken;
	logic        rec_valid;
	logic [23:0] rec_len;
	logic        load_active;

	modport source (output valid, output tone, output cas_out, output cas_in,
		output pulse_taken, output rec_valid, output rec_len, output load_active,
		input ready);
	modport sink (input valid, input tone, input cas_out, input cas_in,
		input pulse_taken, input rec_valid, input rec_len, input load_active,
		output ready);
endinterface

// ===== design/cassette_tone_and_pulse_timer_top.sv =====
// Cassette tone generator and pulse timer, top level.
// Depends on ctp_pkg and the channel interfaces in ctp_if.sv.
//
// Usage: every beat on ticks is one machine clock tick. For each tick the
// block returns exactly one beat on results carrying the tone level, the
// cassette output level, the played cassette input level, whether the offered
// playback pulse length was consumed, and (when recording) the length of the
// gap that just ended, in sample units.
// Configuration is written through the APB-style port while the block is idle;
// register i sits at byte address 4*i and reads back its current value.
//
// Pipeline: a tick beat accepted into the input register (s1) has its result
// computed from that register; the result is loaded into the result register
// (s2) as soon as that register is free, and is offered on results from there.
// Throughput: one tick per cycle while results is not held off. All per-tick
// state (tone phase, gap counter, playback counters) updates in one pass;
// the longest path is the playback target multiplier (length times Q16 ratio,
// rounded and saturated) from the input register into the target register.
// Stalls: when results is held off, the result register keeps its beat and
// the input register can still take one more tick; only when both are full
// does ticks drop ready. Nothing is dropped or repeated.
// Reset: arst_n clears both pipeline valids and returns the registers and the
// tone, gap and playback state to their defaults (playback waiting to start,
// stream considered loaded, input level equal to the initial_level default).
module cassette_tone_and_pulse_timer_top #(
	parameter int unsigned COUNT_WIDTH = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ctp_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	ctp_in_if.sink                     ticks,
	ctp_out_if.source                  results
);

	localparam int unsigned CW   = COUNT_WIDTH;
	// Width of gap_count * Q24 plus rounding, and of the scaled value after >> 24.
	localparam int unsigned RS_W = CW + 25;
	localparam int unsigned RQ_W = RS_W - 24;
	// Width of length * Q16 plus rounding, and of the scaled value after >> 16.
	localparam int unsigned PS_W = 51;
	localparam int unsigned PQ_W = PS_W - 16;
	localparam logic [CW-1:0] COUNT_MAX = '1;

	// Configuration registers.
	logic [15:0] tone_half_q;
	logic [23:0] spc_q24_q;
	logic [25:0] cps_q16_q;
	logic        rec_en_q;
	logic        play_en_q;
	logic        init_level_q;

	// Per-tick state.
	logic [15:0]   tone_phase_q;
	logic          tone_level_q;
	logic          last_cas_out_q;
	logic [CW-1:0] gap_count_q;
	logic          play_level_q;
	logic [CW-1:0] play_elapsed_q;
	logic [CW-1:0] play_target_q;
	logic          start_pending_q;
	logic          loading_q;

	// Pipeline registers.
	logic             valid_s1;
	ctp_pkg::item_t   item_s1;
	logic             valid_s2;
	ctp_pkg::result_t result_s2;

	logic cfg_wr;
	ctp_pkg::reg_idx_t cfg_idx;

	logic out_free;
	logic step;

	// Tone divider signals.
	logic [15:0] half_eff;
	logic [15:0] phase_adj;
	logic [16:0] phase_inc;
	logic [15:0] phase_next;
	logic        tone_next;
	logic        cas_out_c;
	logic        edge_seen;

	// Recording signals.
	logic [RS_W-1:0] rec_sum;
	logic [RQ_W-1:0] rec_scaled;
	logic [23:0]     rec_len_c;
	logic [CW-1:0]   gap_next;

	// Playback signals.
	logic [PS_W-1:0] play_sum;
	logic [PQ_W-1:0] play_scaled;
	logic [CW-1:0]   target_sat;
	logic [CW-1:0]   target_c;
	logic            start_c;
	logic            taken_c;
	logic            level_next;
	logic            loading_next;
	logic            pending_next;
	logic [CW-1:0]   elapsed_next;
	logic [CW-1:0]   target_next;

	ctp_pkg::result_t result_c;

	// ---------------------------------------------------------------------
	// Configuration port
	// ---------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = ctp_pkg::reg_idx_t'(paddr[ctp_pkg::PADDR_W-1:2]);

	always_comb begin
		case (cfg_idx)
			ctp_pkg::REG_TONE_HALF_PERIOD:  prdata = {16'd0, tone_half_q};
			ctp_pkg::REG_SAMPLES_PER_CYCLE: prdata = {8'd0, spc_q24_q};
			ctp_pkg::REG_CYCLES_PER_SAMPLE: prdata = {6'd0, cps_q16_q};
			ctp_pkg::REG_RECORD_ENABLE:     prdata = {31'd0, rec_en_q};
			ctp_pkg::REG_PLAY_ENABLE:       prdata = {31'd0, play_en_q};
			ctp_pkg::REG_INITIAL_LEVEL:     prdata = {31'd0, init_level_q};
			default:                        prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_half_q  <= ctp_pkg::TONE_HALF_RESET;
			spc_q24_q    <= ctp_pkg::SPC_Q24_RESET;
			cps_q16_q    <= ctp_pkg::CPS_Q16_RESET;
			rec_en_q     <= 1'b0;
			play_en_q    <= 1'b0;
			init_level_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				ctp_pkg::REG_TONE_HALF_PERIOD:  tone_half_q  <= pwdata[15:0];
				ctp_pkg::REG_SAMPLES_PER_CYCLE: spc_q24_q    <= pwdata[23:0];
				ctp_pkg::REG_CYCLES_PER_SAMPLE: cps_q16_q    <= pwdata[25:0];
				ctp_pkg::REG_RECORD_ENABLE:     rec_en_q     <= pwdata[0];
				ctp_pkg::REG_PLAY_ENABLE:       play_en_q    <= pwdata[0];
				ctp_pkg::REG_INITIAL_LEVEL:     init_level_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Handshake: input register (s1) and result register (s2)
	// ---------------------------------------------------------------------
	assign out_free    = !valid_s2 || results.ready;
	assign step        = valid_s1 && out_free;
	assign ticks.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ticks.valid && ticks.ready) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				valid_s2 <= 1'b1;
			end else if (results.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ticks.valid && ticks.ready) begin
			item_s1.tone_enable    <= ticks.tone_enable;
			item_s1.tape_data      <= ticks.tape_data;
			item_s1.pulse_avail    <= ticks.pulse_avail;
			item_s1.next_pulse_len <= ticks.next_pulse_len;
		end
		if (step) begin
			result_s2 <= result_c;
		end
	end

	// ---------------------------------------------------------------------
	// Tone divider and cassette output
	// ---------------------------------------------------------------------
	always_comb begin
		// A half period of zero behaves as one; a phase at or beyond a shrunk
		// half period wraps back to zero.
		half_eff   = (tone_half_q == 16'd0) ? 16'd1 : tone_half_q;
		phase_adj  = (tone_phase_q >= half_eff) ? 16'd0 : tone_phase_q;
		tone_next  = tone_level_q ^ (phase_adj == 16'd0);
		phase_inc  = {1'b0, phase_adj} + 17'd1;
		phase_next = (phase_inc >= {1'b0, half_eff}) ? 16'd0 : phase_inc[15:0];
		cas_out_c  = ~((~item_s1.tone_enable | tone_next) & item_s1.tape_data);
		edge_seen  = (cas_out_c != last_cas_out_q);
	end

	// ---------------------------------------------------------------------
	// Gap recording: gap_count * Q24 ratio, round half up, saturate
	// ---------------------------------------------------------------------
	always_comb begin
		rec_sum    = RS_W'(gap_count_q) * RS_W'(spc_q24_q) + RS_W'(ctp_pkg::REC_ROUND);
		rec_scaled = rec_sum[RS_W-1:24];
		if (rec_scaled > RQ_W'(ctp_pkg::REC_MAX)) begin
			rec_len_c = ctp_pkg::REC_MAX;
		end else begin
			rec_len_c = rec_scaled[23:0];
		end
		// An edge restarts the count; it then counts this tick.
		if (edge_seen) begin
			gap_next = CW'(1);
		end else if (gap_count_q == COUNT_MAX) begin
			gap_next = COUNT_MAX;
		end else begin
			gap_next = gap_count_q + CW'(1);
		end
	end

	// ---------------------------------------------------------------------
	// Playback: pulse length * Q16 ratio gives the target in cycles
	// ---------------------------------------------------------------------
	always_comb begin
		play_sum    = PS_W'(item_s1.next_pulse_len) * PS_W'(cps_q16_q)
			+ PS_W'(ctp_pkg::PLAY_ROUND);
		play_scaled = play_sum[PS_W-1:16];
		target_sat  = (play_scaled > PQ_W'(COUNT_MAX)) ? COUNT_MAX : play_scaled[CW-1:0];
		// A target that rounds to zero is replaced by the smallest nonzero target.
		target_c    = (target_sat == '0) ? CW'(1) : target_sat;

		start_c      = 1'b0;
		taken_c      = 1'b0;
		level_next   = play_level_q;
		loading_next = loading_q;
		pending_next = start_pending_q;
		target_next  = play_target_q;
		elapsed_next = play_elapsed_q;

		if (loading_q) begin
			start_c = play_en_q && (start_pending_q || (play_elapsed_q >= play_target_q));
			if (start_c) begin
				pending_next = 1'b0;
				level_next   = ~play_level_q;
				elapsed_next = CW'(1);
				if (item_s1.pulse_avail) begin
					target_next = target_c;
					taken_c     = 1'b1;
				end else begin
					// The stream has run dry: playback stops for good.
					loading_next = 1'b0;
				end
			end else if (play_elapsed_q != COUNT_MAX) begin
				elapsed_next = play_elapsed_q + CW'(1);
			end
		end
	end

	always_comb begin
		result_c.tone        = tone_next;
		result_c.cas_out     = cas_out_c;
		result_c.cas_in      = loading_next & level_next;
		result_c.pulse_taken = taken_c;
		result_c.rec_valid   = edge_seen & rec_en_q;
		result_c.rec_len     = (edge_seen && rec_en_q) ? rec_len_c : 24'd0;
		result_c.load_active = loading_next;
	end

	// ---------------------------------------------------------------------
	// State registers, updated once per tick as it moves into s2
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_phase_q    <= 16'd0;
			tone_level_q    <= 1'b0;
			last_cas_out_q  <= 1'b0;
			gap_count_q     <= '0;
			play_level_q    <= 1'b0;
			play_elapsed_q  <= '0;
			play_target_q   <= '0;
			start_pending_q <= 1'b1;
			loading_q       <= 1'b1;
		end else if (step) begin
			tone_phase_q    <= phase_next;
			tone_level_q    <= tone_next;
			last_cas_out_q  <= cas_out_c;
			gap_count_q     <= gap_next;
			play_level_q    <= level_next;
			play_elapsed_q  <= elapsed_next;
			play_target_q   <= target_next;
			start_pending_q <= pending_next;
			loading_q       <= loading_next;
		end else if (cfg_wr && (cfg_idx == ctp_pkg::REG_INITIAL_LEVEL) && start_pending_q) begin
			// Before the first pulse, the initial level sets the input level.
			play_level_q <= pwdata[0];
		end
	end

	// ---------------------------------------------------------------------
	// Result channel
	// ---------------------------------------------------------------------
	assign results.valid       = valid_s2;
	assign results.tone        = result_s2.tone;
	assign results.cas_out     = result_s2.cas_out;
	assign results.cas_in      = result_s2.cas_in;
	assign results.pulse_taken = result_s2.pulse_taken;
	assign results.rec_valid   = result_s2.rec_valid;
	assign results.rec_len     = result_s2.rec_len;
	assign results.load_active = result_s2.load_active;

endmodule

// ===== design/ctp_port_checker.sv =====
// Port-level checks for the cassette tone and pulse timer, bound to the top.
// Depends on the channel interfaces of the top level only.
module ctp_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        tone,
	input logic        cas_out,
	input logic        cas_in,
	input logic        pulse_taken,
	input logic        rec_valid,
	input logic [23:0] rec_len,
	input logic        load_active
);

	logic dry_q;

	// Set once a delivered beat shows the playback stream as run dry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_q <= 1'b0;
		end else if (out_valid && out_ready && !load_active) begin
			dry_q <= 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rec_len)
			&& $stable(tone) && $stable(cas_out) && $stable(cas_in))
		else $error("result beat changed while stalled");

	a_rec_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rec_valid |-> rec_len == 24'd0)
		else $error("rec_len nonzero without rec_valid");

	a_cas_in_dry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cas_in |-> load_active)
		else $error("cas_in high after the stream ran dry");

	a_taken_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pulse_taken |-> load_active)
		else $error("pulse taken while playback inactive");

	a_dry_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dry_q |-> !load_active && !pulse_taken)
		else $error("playback resumed after the stream ran dry");

endmodule

bind cassette_tone_and_pulse_timer_top ctp_port_checker u_ctp_port_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.tone        (results.tone),
	.cas_out     (results.cas_out),
	.cas_in      (results.cas_in),
	.pulse_taken (results.pulse_taken),
	.rec_valid   (results.rec_valid),
	.rec_len     (results.rec_len),
	.load_active (results.load_active)
);
